@@ design/sspr_pkg.sv @@
// Package for the strobed serial packet receiver.
// Holds the beat types, status codes, register indexes and framing constants.
// No dependencies.
`default_nettype none

package sspr_pkg;

  // One input sample
  typedef struct packed {
    logic begin_req;
    logic strobe_level;
    logic data_level;
  } in_beat_t;

  // One result item
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [3:0] byte_index;
    logic       packet_done;
    logic [1:0] status;
  } out_beat_t;

  // Packet end status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FRAME_ERR = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_EDGE_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TIMEOUT       = 1'b1;

  localparam int unsigned TIMEOUT_W = 16;
  localparam logic [TIMEOUT_W-1:0] FIRST_EDGE_TIMEOUT_RST = 16'd400;
  localparam logic [TIMEOUT_W-1:0] EDGE_TIMEOUT_RST       = 16'd45;

  // Bytes per packet
  localparam logic [3:0] PACKET_BYTES = 4'd13;

  // Bit phases within a frame
  localparam logic [3:0] PHASE_START     = 4'd0;
  localparam logic [3:0] PHASE_LAST_DATA = 4'd8;

endpackage

`default_nettype wire

@@ design/sspr_in_if.sv @@
// Input channel of the strobed serial packet receiver: one line sample per beat.
// No dependencies.
`default_nettype none

interface sspr_in_if;
  logic valid;
  logic ready;
  logic begin_req;
  logic strobe_level;
  logic data_level;

  modport source (output valid, begin_req, strobe_level, data_level, input ready);
  modport sink   (input valid, begin_req, strobe_level, data_level, output ready);
endinterface

`default_nettype wire

@@ design/sspr_out_if.sv @@
// Output channel of the strobed serial packet receiver: one result item per beat.
// No dependencies.
`default_nettype none

interface sspr_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [3:0] byte_index;
  logic       packet_done;
  logic [1:0] status;

  modport source (output valid, byte_valid, byte_value, byte_index, packet_done, status,
                  input ready);
  modport sink   (input valid, byte_valid, byte_value, byte_index, packet_done, status,
                  output ready);
endinterface

`default_nettype wire

@@ design/sspr_in_stage.sv @@
// Input register of the receiver: captures one sample beat and holds it until
// the framing logic consumes it. Depends on sspr_pkg and sspr_in_if.
`default_nettype none

module sspr_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  sspr_in_if.sink         in_i,
  input  wire logic       adv_i,
  output logic            valid_o,
  output sspr_pkg::in_beat_t beat_o
);

  logic               valid_q, valid_d;
  logic               take;
  sspr_pkg::in_beat_t beat_q;

  // Accept while empty or while the held beat moves on
  assign in_i.ready = ~valid_q | adv_i;
  assign take       = in_i.valid & in_i.ready;
  assign valid_d    = take | (valid_q & ~adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the beat payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      beat_q <= '{begin_req:    in_i.begin_req,
                  strobe_level: in_i.strobe_level,
                  data_level:   in_i.data_level};
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

@@ design/sspr_frame.sv @@
// Frame decoder of the receiver: strobe edge detection, bit shifting, framing
// checks and timeouts for one sample per step. Depends on sspr_pkg.
`default_nettype none

module sspr_frame (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              step_i,
  input  wire sspr_pkg::in_beat_t                beat_i,
  input  wire logic [sspr_pkg::TIMEOUT_W-1:0]    first_edge_timeout_i,
  input  wire logic [sspr_pkg::TIMEOUT_W-1:0]    edge_timeout_i,
  output logic                                   res_valid_o,
  output sspr_pkg::out_beat_t                    res_o
);

  logic                           receiving_q, receiving_d;
  logic                           last_strobe_q, last_strobe_d;
  logic [3:0]                     bytes_done_q, bytes_done_d;
  logic [3:0]                     bit_phase_q, bit_phase_d;
  logic [7:0]                     shift_byte_q, shift_byte_d;
  logic [sspr_pkg::TIMEOUT_W-1:0] countdown_q, countdown_d;
  logic [sspr_pkg::TIMEOUT_W-1:0] countdown_dec;
  logic                           strobe_edge;
  logic [2:0]                     bit_sel;
  logic [4:0]                     bytes_next;

  assign strobe_edge   = last_strobe_q & ~beat_i.strobe_level;
  assign countdown_dec = (countdown_q == '0) ? '0 : countdown_q - 1'b1;
  assign bit_sel       = 3'(bit_phase_q - 4'd1);
  assign bytes_next    = {1'b0, bytes_done_q} + 5'd1;

  // Next state and result for the current sample
  always_comb begin
    receiving_d   = receiving_q;
    last_strobe_d = last_strobe_q;
    bytes_done_d  = bytes_done_q;
    bit_phase_d   = bit_phase_q;
    shift_byte_d  = shift_byte_q;
    countdown_d   = countdown_q;
    res_valid_o   = 1'b0;
    res_o         = '{byte_valid: 1'b0, byte_value: 8'd0, byte_index: bytes_done_q,
                      packet_done: 1'b1, status: sspr_pkg::STATUS_OK};

    if (beat_i.begin_req) begin
      // Open a packet, dropping any open one
      receiving_d   = 1'b1;
      last_strobe_d = beat_i.strobe_level;
      bytes_done_d  = 4'd0;
      bit_phase_d   = sspr_pkg::PHASE_START;
      shift_byte_d  = 8'd0;
      countdown_d   = first_edge_timeout_i;
    end else begin
      last_strobe_d = beat_i.strobe_level;
      if (receiving_q) begin
        if (!strobe_edge) begin
          countdown_d = countdown_dec;
          if (countdown_dec == '0) begin
            receiving_d  = 1'b0;
            res_valid_o  = 1'b1;
            res_o.status = sspr_pkg::STATUS_TIMEOUT;
          end
        end else begin
          countdown_d = edge_timeout_i;
          if (bit_phase_q == sspr_pkg::PHASE_START) begin
            // Start bit must be raw 1
            shift_byte_d = 8'd0;
            if (!beat_i.data_level) begin
              receiving_d  = 1'b0;
              res_valid_o  = 1'b1;
              res_o.status = sspr_pkg::STATUS_FRAME_ERR;
            end else begin
              bit_phase_d = 4'd1;
            end
          end else if (bit_phase_q <= sspr_pkg::PHASE_LAST_DATA) begin
            // Shift in an inverted data bit, LSB first
            shift_byte_d[bit_sel] = shift_byte_q[bit_sel] | ~beat_i.data_level;
            bit_phase_d = bit_phase_q + 4'd1;
          end else begin
            // Stop bit must be raw 0
            if (beat_i.data_level) begin
              receiving_d  = 1'b0;
              res_valid_o  = 1'b1;
              res_o.status = sspr_pkg::STATUS_FRAME_ERR;
            end else begin
              bit_phase_d  = sspr_pkg::PHASE_START;
              bytes_done_d = bytes_next[3:0];
              res_valid_o  = 1'b1;
              res_o.byte_valid  = 1'b1;
              res_o.byte_value  = shift_byte_q;
              res_o.packet_done = (bytes_next >= {1'b0, sspr_pkg::PACKET_BYTES});
              if (res_o.packet_done) begin
                receiving_d = 1'b0;
              end
            end
          end
        end
      end
    end
  end

  // Advance state once per consumed sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q   <= 1'b0;
      last_strobe_q <= 1'b0;
      bytes_done_q  <= 4'd0;
      bit_phase_q   <= sspr_pkg::PHASE_START;
      shift_byte_q  <= 8'd0;
      countdown_q   <= '0;
    end else if (step_i) begin
      receiving_q   <= receiving_d;
      last_strobe_q <= last_strobe_d;
      bytes_done_q  <= bytes_done_d;
      bit_phase_q   <= bit_phase_d;
      shift_byte_q  <= shift_byte_d;
      countdown_q   <= countdown_d;
    end
  end

endmodule

`default_nettype wire

@@ design/sspr_out_reg.sv @@
// Result register of the receiver: holds one result beat until the sink takes it.
// Depends on sspr_pkg and sspr_out_if.
`default_nettype none

module sspr_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire sspr_pkg::out_beat_t beat_i,
  output logic                     free_o,
  sspr_out_if.source               out_o
);

  logic                valid_q, valid_d;
  sspr_pkg::out_beat_t beat_q;

  // Free when empty or when the held beat leaves this cycle
  assign free_o  = ~valid_q | out_o.ready;
  assign valid_d = load_i | (valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      beat_q <= beat_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.byte_valid  = beat_q.byte_valid;
  assign out_o.byte_value  = beat_q.byte_value;
  assign out_o.byte_index  = beat_q.byte_index;
  assign out_o.packet_done = beat_q.packet_done;
  assign out_o.status      = beat_q.status;

endmodule

`default_nettype wire

@@ design/strobed_serial_packet_receiver.sv @@
// Strobed serial packet receiver, top level.
// Path: a sample beat is accepted into the input register, then decoded
// into the result register, which presents the result.
// Throughput: one sample beat per cycle; a held result stalls every sample, with or without
// a result, until the sink takes it, and the slot frees in that same cycle.
// Reset clears all framing state and loads the timeout registers with 400 and 45.
`default_nettype none

module strobed_serial_packet_receiver (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  sspr_in_if.sink                                  in_i,
  sspr_out_if.source                               out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [sspr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [sspr_pkg::TIMEOUT_W-1:0]      cfg_data_i
);

  logic                           s1_valid;
  sspr_pkg::in_beat_t             s1_beat;
  logic                           out_free;
  logic                           step;
  logic                           res_valid;
  sspr_pkg::out_beat_t            res;
  logic [sspr_pkg::TIMEOUT_W-1:0] first_edge_timeout_q;
  logic [sspr_pkg::TIMEOUT_W-1:0] edge_timeout_q;

  // Timeout registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_edge_timeout_q <= sspr_pkg::FIRST_EDGE_TIMEOUT_RST;
      edge_timeout_q       <= sspr_pkg::EDGE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sspr_pkg::CFG_FIRST_EDGE_TIMEOUT: first_edge_timeout_q <= cfg_data_i;
        sspr_pkg::CFG_EDGE_TIMEOUT:       edge_timeout_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sspr_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (out_free),
    .valid_o (s1_valid),
    .beat_o  (s1_beat)
  );

  // Consume a held sample whenever the result slot can take its result
  assign step = s1_valid & out_free;

  sspr_frame u_frame (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .step_i               (step),
    .beat_i               (s1_beat),
    .first_edge_timeout_i (first_edge_timeout_q),
    .edge_timeout_i       (edge_timeout_q),
    .res_valid_o          (res_valid),
    .res_o                (res)
  );

  sspr_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step & res_valid),
    .beat_i (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
